>>> rtl/transfer_request_encoder_macros.svh
// ----------------------------------------------------------------------------
// Transfer request encoder assertion macros
// Clocked assertion wrappers used by the RTL datapath.
// ----------------------------------------------------------------------------
`ifndef TRANSFER_REQUEST_ENCODER_MACROS_SVH
`define TRANSFER_REQUEST_ENCODER_MACROS_SVH

// checked outside reset only
`define TRE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked in every cycle, reset included
`define TRE_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/tre_pkg.sv
// ----------------------------------------------------------------------------
// Transfer request encoder package
// Types, codes and control word builders shared by the encoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package tre_pkg;

  localparam int unsigned RING_ENTRIES = 85;
  localparam int unsigned MAX_CHUNKS   = 64;

  localparam int unsigned SLOT_W      = 7;
  localparam int unsigned CHUNK_BYTES = 32'h200;
  localparam int unsigned DST_STRIDE  = 32'h400;
  localparam int unsigned BYTE_LIMIT  = MAX_CHUNKS * CHUNK_BYTES;
  localparam int unsigned REM_W       = $clog2(BYTE_LIMIT + 1);
  localparam int unsigned CHUNK_W     = $clog2(CHUNK_BYTES + 1);

  localparam logic [3:0] FUNC_COPY   = 4'd1;
  localparam logic [3:0] FUNC_IMM_A  = 4'd2;
  localparam logic [3:0] FUNC_ROW_A  = 4'd3;
  localparam logic [3:0] FUNC_ROW_B  = 4'd4;
  localparam logic [3:0] FUNC_IMM_B  = 4'd5;
  localparam logic [3:0] FUNC_FILL   = 4'd6;
  localparam logic [3:0] FUNC_DECOMP = 4'd8;

  typedef enum logic [1:0] {
    KIND_QUEUED = 2'd0,
    KIND_COPY   = 2'd1,
    KIND_FILL   = 2'd2,
    KIND_DECOMP = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } tre_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic out_free;
  } tre_status_t;

  function automatic logic [31:0] copy_control(logic [31:0] src, logic [31:0] dst,
                                               logic [23:0] size);
    logic [31:0] ctl;
    if (((src | dst | {8'b0, size}) & 32'h3) != 32'h0) begin
      ctl = {5'b0, size[23:1], 4'b0000};
    end else if (size[4:0] != 5'b0) begin
      ctl = {4'b0100, 2'b00, size[23:2], 4'b0000};
    end else begin
      ctl = {6'b0, size[23:2], 4'b0001};
    end
    return ctl;
  endfunction

  function automatic logic [31:0] fill_control(logic [31:0] dst, logic [23:0] size);
    logic [31:0] ctl;
    if (((dst | {8'b0, size}) & 32'h3) != 32'h0) begin
      ctl = {3'b000, 1'b1, 1'b0, size[23:1], 4'b0010};
    end else if (size[4:0] != 5'b0) begin
      ctl = {4'b0101, 2'b00, size[23:2], 4'b0010};
    end else begin
      ctl = {4'b0001, 2'b00, size[23:2], 4'b0011};
    end
    return ctl;
  endfunction

  function automatic logic [31:0] count_word(logic [23:0] size);
    return {11'b0, size[21:1]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/tre_if.sv
// ----------------------------------------------------------------------------
// Transfer request encoder channels
// Valid/ready channels for requests and for encoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tre_req_if import tre_pkg::*;;
  logic              valid;
  logic              ready;
  logic [3:0]        func;
  logic [31:0]       src_addr;
  logic [31:0]       dst_addr;
  logic [23:0]       byte_count;
  logic              forced_blank;
  logic [SLOT_W-1:0] consumer_slot;

  modport source (output valid, func, src_addr, dst_addr, byte_count, forced_blank,
                  consumer_slot, input ready);
  modport sink   (input valid, func, src_addr, dst_addr, byte_count, forced_blank,
                  consumer_slot, output ready);
endinterface

interface tre_res_if import tre_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [31:0]       word_control;
  logic [31:0]       word_source;
  logic [31:0]       word_dest;
  logic [SLOT_W-1:0] ring_slot;
  logic              ring_full;
  logic              last;

  modport source (output valid, kind, word_control, word_source, word_dest, ring_slot,
                  ring_full, last, input ready);
  modport sink   (input valid, kind, word_control, word_source, word_dest, ring_slot,
                  ring_full, last, output ready);
endinterface

`default_nettype wire

>>> rtl/tre_ctrl.sv
// ----------------------------------------------------------------------------
// Transfer request encoder controller
// Takes a request, then steps the datapath once per result.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_ctrl import tre_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire tre_status_t status,
  output tre_cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.empty || (status.out_free && status.last)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EMIT: begin
        cmd.emit = !status.empty && status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/tre_dp.sv
// ----------------------------------------------------------------------------
// Transfer request encoder datapath
// Request registers, chunk walker, ring write slot and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "transfer_request_encoder_macros.svh"

module tre_dp import tre_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tre_cmd_t          cmd,
  output tre_status_t            status,
  input  wire logic [3:0]        in_func,
  input  wire logic [31:0]       in_src_addr,
  input  wire logic [31:0]       in_dst_addr,
  input  wire logic [23:0]       in_byte_count,
  input  wire logic              in_forced_blank,
  input  wire logic [SLOT_W-1:0] in_consumer_slot,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [1:0]             out_kind,
  output logic [31:0]            out_word_control,
  output logic [31:0]            out_word_source,
  output logic [31:0]            out_word_dest,
  output logic [SLOT_W-1:0]      out_ring_slot,
  output logic                   out_ring_full,
  output logic                   out_last
);

  logic [3:0]         func_r;
  logic [31:0]        src_r, src_nxt;
  logic [31:0]        dst_r, dst_nxt;
  logic [23:0]        size_r;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               blank_r;
  logic [SLOT_W-1:0]  cons_r;
  logic [SLOT_W-1:0]  write_slot_r, write_slot_nxt;

  logic               ovalid_r, ovalid_nxt;
  kind_t              kind_r;
  logic [31:0]        ctl_r, srcw_r, dstw_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               full_r, last_r;

  logic               is_row, is_valid, res_q, res_last;
  logic [CHUNK_W-1:0] chunk;
  logic [23:0]        csize;
  logic [SLOT_W-1:0]  slot_inc;
  kind_t              res_kind;
  logic [31:0]        res_ctl, res_src;

  assign is_row   = (func_r == FUNC_ROW_A) || (func_r == FUNC_ROW_B);
  assign chunk    = (rem_r < REM_W'(CHUNK_BYTES)) ? rem_r[CHUNK_W-1:0]
                                                  : CHUNK_W'(CHUNK_BYTES);
  assign csize    = is_row ? 24'(chunk) : size_r;
  assign res_last = !is_row || (rem_r <= REM_W'(CHUNK_BYTES));
  assign slot_inc = (write_slot_r == SLOT_W'(RING_ENTRIES - 1)) ? '0
                                                                 : write_slot_r + 1'b1;

  always_comb begin
    is_valid = 1'b1;
    res_q    = 1'b0;
    res_kind = KIND_COPY;
    res_ctl  = count_word(csize);
    res_src  = src_r;
    case (func_r)
      FUNC_COPY, FUNC_ROW_A, FUNC_ROW_B: begin
        if (!blank_r) begin
          res_q    = 1'b1;
          res_kind = KIND_QUEUED;
          res_ctl  = copy_control(src_r, dst_r, csize);
        end
      end
      FUNC_IMM_A, FUNC_IMM_B: begin
        res_kind = KIND_COPY;
      end
      FUNC_FILL: begin
        res_src = {src_r[15:0], src_r[15:0]};
        if (blank_r) begin
          res_kind = KIND_FILL;
          res_ctl  = count_word(size_r) | 32'h0100_0000;
        end else begin
          res_q    = 1'b1;
          res_kind = KIND_QUEUED;
          res_ctl  = fill_control(dst_r, size_r);
        end
      end
      FUNC_DECOMP: begin
        res_kind = KIND_DECOMP;
        res_ctl  = '0;
      end
      default: begin
        is_valid = 1'b0;
      end
    endcase
  end

  assign status.empty    = !is_valid || (is_row && (rem_r == '0));
  assign status.last     = res_last;
  assign status.out_free = !ovalid_r || out_ready;

  always_comb begin
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    rem_nxt        = rem_r;
    write_slot_nxt = write_slot_r;
    if (cmd.load) begin
      src_nxt = in_src_addr;
      dst_nxt = (in_func == FUNC_ROW_B) ? in_dst_addr + 32'(CHUNK_BYTES) : in_dst_addr;
      rem_nxt = (in_byte_count > 24'(BYTE_LIMIT)) ? REM_W'(BYTE_LIMIT)
                                                  : in_byte_count[REM_W-1:0];
    end else if (cmd.emit) begin
      if (is_row) begin
        src_nxt = src_r + 32'(CHUNK_BYTES);
        dst_nxt = dst_r + 32'(DST_STRIDE);
        rem_nxt = rem_r - REM_W'(chunk);
      end
      if (res_q) begin
        write_slot_nxt = slot_inc;
      end
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      ovalid_r     <= 1'b0;
    end else begin
      write_slot_r <= write_slot_nxt;
      ovalid_r     <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    dst_r <= dst_nxt;
    rem_r <= rem_nxt;
    if (cmd.load) begin
      func_r  <= in_func;
      size_r  <= in_byte_count;
      blank_r <= in_forced_blank;
      cons_r  <= in_consumer_slot;
    end
    if (cmd.emit) begin
      kind_r <= res_kind;
      ctl_r  <= res_ctl;
      srcw_r <= res_src;
      dstw_r <= dst_r;
      slot_r <= write_slot_r;
      full_r <= res_q && (slot_inc == cons_r);
      last_r <= res_last;
    end
  end

  assign out_valid        = ovalid_r;
  assign out_kind         = kind_r;
  assign out_word_control = ctl_r;
  assign out_word_source  = srcw_r;
  assign out_word_dest    = dstw_r;
  assign out_ring_slot    = slot_r;
  assign out_ring_full    = full_r;
  assign out_last         = last_r;

  `TRE_ASSERT(a_slot_range, clk, rst_n, write_slot_r < SLOT_W'(RING_ENTRIES), "write slot out of range")
  `TRE_ASSERT(a_full_queued, clk, rst_n, ovalid_r && full_r |-> kind_r == KIND_QUEUED, "ring full on non-queued result")
  `TRE_ASSERT(a_slot_moves, clk, rst_n, cmd.emit && res_q |=> write_slot_r != $past(write_slot_r), "queued entry did not advance slot")
  `TRE_ASSERT_RST(a_rst_clear, clk, !rst_n |=> !ovalid_r, "result valid after reset")

endmodule

`default_nettype wire

>>> rtl/transfer_request_encoder.sv
// ----------------------------------------------------------------------------
// Transfer request encoder: requests to immediate ops or queued ring entries.
// First result: registered from the emit state that follows the request.
// Requests: one at a time, taken in idle; rows emit one result per chunk.
// Reset: synchronous, clears the ring write slot to 0 and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module transfer_request_encoder import tre_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  tre_req_if.sink   in_req,
  tre_res_if.source out_res
);

  tre_cmd_t    cmd;
  tre_status_t status;

  tre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tre_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_func          (in_req.func),
    .in_src_addr      (in_req.src_addr),
    .in_dst_addr      (in_req.dst_addr),
    .in_byte_count    (in_req.byte_count),
    .in_forced_blank  (in_req.forced_blank),
    .in_consumer_slot (in_req.consumer_slot),
    .out_ready        (out_res.ready),
    .out_valid        (out_res.valid),
    .out_kind         (out_res.kind),
    .out_word_control (out_res.word_control),
    .out_word_source  (out_res.word_source),
    .out_word_dest    (out_res.word_dest),
    .out_ring_slot    (out_res.ring_slot),
    .out_ring_full    (out_res.ring_full),
    .out_last         (out_res.last)
  );

endmodule

`default_nettype wire

>>> verif/transfer_request_encoder_tb.sv
// ----------------------------------------------------------------------------
// Transfer request encoder testbench
// Drives transfer requests through a directed table and then random traffic.
// A predictor of the ring write slot and result encoding builds the expected
// transactions, which are compared field by field as results are accepted.
// Both channels stall in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module transfer_request_encoder_tb;
  import tre_pkg::*;

  localparam int          RANDOM_ITEMS  = 326;
  localparam int          QUIET_TAIL    = 60;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES  = 16;
  localparam int          N_DIRECTED    = 24;
  localparam logic [31:0] COUNT_MASK    = 32'h001F_FFFF;
  localparam logic [31:0] WORD_FLAG     = 32'h0400_0000;
  localparam logic [31:0] FILL_FLAG     = 32'h0100_0000;
  localparam logic [31:0] FILL_WORD_FLAG = 32'h0500_0000;
  localparam logic [3:0]  FUNC_NOP      = 4'd0;
  localparam logic [3:0]  FUNC_RSVD_7   = 4'd7;
  localparam logic [3:0]  FUNC_RSVD_9   = 4'd9;
  localparam logic [3:0]  FUNC_RSVD_15  = 4'd15;

  typedef struct packed {
    logic [3:0]        func;
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [23:0]       size;
    logic              blank;
    logic [SLOT_W-1:0] consumer;
  } request_t;

  typedef struct packed {
    kind_t             kind;
    logic [31:0]       ctl;
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [SLOT_W-1:0] slot;
    logic              full;
    logic              last;
  } encoded_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    encoded_t res;
  } directed_row_t;

  localparam encoded_t UNTYPED = '0;

  logic clk;
  logic rst_n;

  tre_req_if req_if ();
  tre_res_if res_if ();

  transfer_request_encoder i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_res (res_if)
  );

  encoded_t          pending_results[$];
  logic [SLOT_W-1:0] ring_wr_slot;
  bit                idling;
  int                mismatches;
  int                requests_sent;
  int                results_checked;
  int                queued_seen;
  int                full_seen;
  int                quiet_cycles;

  // rows with a typed result produce exactly one transaction
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{FUNC_COPY, 32'h0, 32'h0, 24'h20, 1'b0, 7'd1}, 1'b1,
      '{KIND_QUEUED, 32'h81, 32'h0, 32'h0, 7'd0, 1'b1, 1'b1}},
    '{'{FUNC_DECOMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, 7'h7F}, 1'b1,
      '{KIND_DECOMP, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1, 1'b0, 1'b1}},
    '{'{FUNC_IMM_A, 32'h0, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, 7'd2}, 1'b1,
      '{KIND_COPY, 32'h001F_FFFF, 32'h0, 32'hFFFF_FFFF, 7'd1, 1'b0, 1'b1}},
    '{'{FUNC_IMM_B, 32'hFFFF_FFFF, 32'h0, 24'h0, 1'b1, 7'd2}, 1'b1,
      '{KIND_COPY, 32'h0, 32'hFFFF_FFFF, 32'h0, 7'd1, 1'b0, 1'b1}},
    '{'{FUNC_FILL, 32'hABCD_1234, 32'h0600_0000, 24'hFF_FFFF, 1'b1, 7'd2}, 1'b1,
      '{KIND_FILL, 32'h011F_FFFF, 32'h1234_1234, 32'h0600_0000, 7'd1, 1'b0, 1'b1}},
    '{'{FUNC_COPY, 32'h0200_0000, 32'h0600_0000, 24'h1235, 1'b1, 7'd0}, 1'b0, UNTYPED},
    '{'{FUNC_NOP, 32'h1, 32'h2, 24'h10, 1'b0, 7'd0}, 1'b0, UNTYPED},
    '{'{FUNC_RSVD_7, 32'h1, 32'h2, 24'h10, 1'b0, 7'd0}, 1'b0, UNTYPED},
    '{'{FUNC_RSVD_9, 32'h1, 32'h2, 24'h10, 1'b1, 7'd0}, 1'b0, UNTYPED},
    '{'{FUNC_RSVD_15, 32'h1, 32'h2, 24'h10, 1'b0, 7'd0}, 1'b0, UNTYPED},
    '{'{FUNC_COPY, 32'h0800_0001, 32'h0600_0000, 24'h101, 1'b0, 7'h7F}, 1'b0, UNTYPED},
    '{'{FUNC_COPY, 32'h0800_0000, 32'h0600_0100, 24'h24, 1'b0, 7'd3}, 1'b0, UNTYPED},
    '{'{FUNC_FILL, 32'h0000_FFFF, 32'h0600_0002, 24'h6, 1'b0, 7'd4}, 1'b0, UNTYPED},
    '{'{FUNC_FILL, 32'h5555_AAAA, 32'h0600_0000, 24'h44, 1'b0, 7'd6}, 1'b0, UNTYPED},
    '{'{FUNC_FILL, 32'hFFFF_0000, 32'h0600_0400, 24'h40, 1'b0, 7'd6}, 1'b0, UNTYPED},
    '{'{FUNC_ROW_A, 32'h0200_0000, 32'h0600_0000, 24'h0, 1'b0, 7'd7}, 1'b0, UNTYPED},
    '{'{FUNC_ROW_A, 32'h0200_0003, 32'h0600_0000, 24'h1, 1'b0, 7'd7}, 1'b0, UNTYPED},
    '{'{FUNC_ROW_B, 32'h0200_0000, 32'h0600_0000, 24'h201, 1'b0, 7'd9}, 1'b0, UNTYPED},
    '{'{FUNC_ROW_A, 32'hFFFF_FE00, 32'hFFFF_FC00, 24'hFF_FFFF, 1'b0, 7'd40}, 1'b0,
      UNTYPED},
    '{'{FUNC_ROW_B, 32'h0200_0000, 32'hFFFF_FE00, 24'h600, 1'b1, 7'd0}, 1'b0, UNTYPED},
    '{'{FUNC_ROW_A, 32'h0300_0000, 32'h0700_0000, 24'h8000, 1'b0, 7'd0}, 1'b0, UNTYPED},
    '{'{FUNC_COPY, 32'h0300_0000, 32'h0700_0000, 24'h40, 1'b0, 7'h7F}, 1'b0, UNTYPED},
    '{'{FUNC_DECOMP, 32'h0, 32'h0, 24'h0, 1'b0, 7'd0}, 1'b0, UNTYPED},
    '{'{FUNC_FILL, 32'hFFFF_0000, 32'h0600_0003, 24'hFF_FFFF, 1'b0, 7'd5}, 1'b0,
      UNTYPED}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] copy_ctl(logic [31:0] src, logic [31:0] dst,
                                           logic [31:0] size);
    if (((src | dst | size) & 32'h3) != 32'h0) return (size >> 1) << 4;
    if (size[4:0] != 5'b0) return ((size >> 2) | WORD_FLAG) << 4;
    return ((size >> 2) << 4) | 32'h1;
  endfunction

  function automatic encoded_t immediate(kind_t kind, logic [31:0] ctl, logic [31:0] src,
                                         logic [31:0] dst);
    return '{kind, ctl, src, dst, ring_wr_slot, 1'b0, 1'b0};
  endfunction

  // writes the ring entry and advances the write slot
  function automatic encoded_t ring_entry(logic [31:0] ctl, logic [31:0] src,
                                          logic [31:0] dst, logic [SLOT_W-1:0] consumer);
    encoded_t          e;
    logic [SLOT_W-1:0] nxt;
    nxt = (ring_wr_slot == SLOT_W'(RING_ENTRIES - 1)) ? '0 : ring_wr_slot + 1'b1;
    e = '{KIND_QUEUED, ctl, src, dst, ring_wr_slot, nxt == consumer, 1'b0};
    ring_wr_slot = nxt;
    return e;
  endfunction

  function automatic logic [SLOT_W-1:0] next_ring_slot();
    return (ring_wr_slot == SLOT_W'(RING_ENTRIES - 1)) ? '0 : ring_wr_slot + 1'b1;
  endfunction

  task automatic encode_request(input request_t r, output encoded_t res[$]);
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] size;
    logic [31:0] chunk;
    logic [31:0] word;
    logic [31:0] ctl;
    encoded_t    e;
    res.delete();
    src  = r.src;
    dst  = r.dst;
    size = 32'(r.size);
    case (r.func)
      FUNC_COPY: begin
        if (r.blank) res.push_back(immediate(KIND_COPY, (size >> 1) & COUNT_MASK, src, dst));
        else res.push_back(ring_entry(copy_ctl(src, dst, size), src, dst, r.consumer));
      end
      FUNC_IMM_A, FUNC_IMM_B: begin
        res.push_back(immediate(KIND_COPY, (size >> 1) & COUNT_MASK, src, dst));
      end
      FUNC_ROW_A, FUNC_ROW_B: begin
        if (r.func == FUNC_ROW_B) dst = dst + CHUNK_BYTES;
        if (size > BYTE_LIMIT) size = BYTE_LIMIT;
        while (size != 0) begin
          chunk = (size < CHUNK_BYTES) ? size : CHUNK_BYTES;
          size  = size - chunk;
          if (r.blank) begin
            res.push_back(immediate(KIND_COPY, (chunk >> 1) & COUNT_MASK, src, dst));
          end else begin
            res.push_back(ring_entry(copy_ctl(src, dst, chunk), src, dst, r.consumer));
          end
          src = src + CHUNK_BYTES;
          dst = dst + DST_STRIDE;
        end
      end
      FUNC_FILL: begin
        word = {src[15:0], src[15:0]};
        if (r.blank) begin
          res.push_back(immediate(KIND_FILL, ((size >> 1) & COUNT_MASK) | FILL_FLAG, word,
                                  dst));
        end else begin
          if (((dst | size) & 32'h3) != 32'h0) ctl = (((size >> 1) | FILL_FLAG) << 4) | 32'h2;
          else if (size[4:0] != 5'b0) ctl = (((size >> 2) | FILL_WORD_FLAG) << 4) | 32'h2;
          else ctl = (((size >> 2) | FILL_FLAG) << 4) | 32'h3;
          res.push_back(ring_entry(ctl, word, dst, r.consumer));
        end
      end
      FUNC_DECOMP: begin
        res.push_back(immediate(KIND_DECOMP, 32'h0, src, dst));
      end
      default: ;
    endcase
    if (res.size() != 0) begin
      e = res.pop_back();
      e.last = 1'b1;
      res.push_back(e);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic request_t random_request();
    request_t r;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4:        r.func = FUNC_COPY;
      5, 6, 7:              r.func = FUNC_ROW_A;
      8, 9, 10:             r.func = FUNC_ROW_B;
      11:                   r.func = FUNC_IMM_A;
      12:                   r.func = FUNC_IMM_B;
      13, 14, 15:           r.func = FUNC_FILL;
      16:                   r.func = FUNC_DECOMP;
      17:                   r.func = FUNC_NOP;
      18:                   r.func = FUNC_RSVD_7;
      default:              r.func = 4'($urandom_range(FUNC_RSVD_9, FUNC_RSVD_15));
    endcase
    r.src = $urandom;
    r.dst = $urandom;
    if ($urandom_range(0, 1) == 0) begin
      r.src[1:0] = 2'b00;
      r.dst[1:0] = 2'b00;
    end
    case ($urandom_range(0, 7))
      0:       r.size = 24'($urandom);
      1:       r.size = 24'h0;
      default: r.size = 24'($urandom_range(1, 4096));
    endcase
    case ($urandom_range(0, 2))
      0:       r.size[4:0] = 5'b0;
      1:       r.size[1:0] = 2'b0;
      default: ;
    endcase
    r.blank = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 2))
      0:       r.consumer = next_ring_slot();
      1:       r.consumer = SLOT_W'($urandom_range(0, RING_ENTRIES - 1));
      default: r.consumer = SLOT_W'($urandom_range(0, 127));
    endcase
    return r;
  endfunction

  task automatic send_request(input request_t r, input logic typed, input encoded_t typed_res,
                              output int n_results);
    encoded_t predicted[$];
    if (idling && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.func          <= r.func;
    req_if.src_addr      <= r.src;
    req_if.dst_addr      <= r.dst;
    req_if.byte_count    <= r.size;
    req_if.forced_blank  <= r.blank;
    req_if.consumer_slot <= r.consumer;
    do @(posedge clk); while (!req_if.ready);
    encode_request(r, predicted);
    n_results = predicted.size();
    if (typed) pending_results.push_back(typed_res);
    else foreach (predicted[i]) pending_results.push_back(predicted[i]);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    request_t r;
    int       n_results;
    int       counted;
    int       silent_requests;
    req_if.valid         = 1'b0;
    req_if.func          = FUNC_NOP;
    req_if.src_addr      = '0;
    req_if.dst_addr      = '0;
    req_if.byte_count    = '0;
    req_if.forced_blank  = 1'b0;
    req_if.consumer_slot = '0;
    rst_n           = 1'b0;
    ring_wr_slot    = '0;
    idling          = 1'b1;
    silent_requests = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res,
                   n_results);
    end
    // hold requests back until the ring traffic has fully drained
    req_if.valid <= 1'b0;
    @(negedge clk);
    wait_drained();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      idling = (counted < RANDOM_ITEMS - QUIET_TAIL) && ((counted / 40) % 3 != 2);
      if (idling && $urandom_range(0, 59) == 0) begin
        req_if.valid <= 1'b0;
        @(negedge clk);
        wait_drained();
      end
      r = random_request();
      send_request(r, 1'b0, UNTYPED, n_results);
      if (n_results == 0) silent_requests++;
      counted++;
    end

    req_if.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d requests (%0d random ones silent) and %0d result transactions.",
             requests_sent, silent_requests, results_checked);
    $display("Ring entries: %0d queued, %0d with ring-full raised.", queued_seen, full_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------- results

  initial begin : result_ready
    int stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got_v,
                             input logic [31:0] want_v);
    if (got_v !== want_v) report_mismatch(what, got_v, want_v);
  endtask

  always @(posedge clk) begin : check_results
    encoded_t got;
    encoded_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = '{kind_t'(res_if.kind), res_if.word_control, res_if.word_source,
              res_if.word_dest, res_if.ring_slot, res_if.ring_full, res_if.last};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, control", got.ctl, 32'h0);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("word_control", got.ctl, want.ctl);
        check_field("word_source", got.src, want.src);
        check_field("word_dest", got.dst, want.dst);
        check_field("ring_slot", 32'(got.slot), 32'(want.slot));
        check_field("ring_full", 32'(got.full), 32'(want.full));
        check_field("last", 32'(got.last), 32'(want.last));
        results_checked++;
        if (want.kind == KIND_QUEUED) queued_seen++;
        if (want.full) full_seen++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
